// ----- rtl/core/sliding_median_u16_core_assert.svh -----
// Assertion macros shared by the sliding median core.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SLIDING_MEDIAN_U16_CORE_ASSERT_SVH
`define SLIDING_MEDIAN_U16_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sliding median assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SMED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sliding median assertion failed");

`endif

// ----- rtl/core/smed_pkg.sv -----
// Package of the sliding median core: sizes, reset length and the structs
// passed between the top level and the sorted cells. No dependencies.
package smed_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W      = 5;
  localparam int DATA_W     = 16;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(5);

  // What one cell shows its neighbors.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  age;
    logic              le;
    logic              act;
  } smed_nbr_t;

  // Common control broadcast to every cell.
  typedef struct packed {
    logic              shift;
    logic              clear;
    logic [DATA_W-1:0] sample;
    logic [IDX_W-1:0]  oldest_age;
    logic [LEN_W-1:0]  clr_len;
  } smed_ctl_t;

endpackage

// ----- rtl/core/smed_cell.sv -----
// One cell of the sorted window chain: holds a sample, its age and an active flag.
// Depends on smed_pkg.
module smed_cell import smed_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  cell_idx,
  input  smed_ctl_t         ctl,
  input  smed_nbr_t         left_nbr,
  input  smed_nbr_t         right_nbr,
  input  logic              shifted_in,
  output logic              shifted_out,
  output smed_nbr_t         own_nbr,
  output logic              oldest,
  output logic [DATA_W-1:0] value_nxt
);

  logic [DATA_W-1:0] value_r;
  logic [IDX_W-1:0]  age_r, age_nxt;
  logic              act_r, act_nxt;
  smed_nbr_t         cur, prv;

  always_comb begin
    oldest      = act_r && (age_r == ctl.oldest_age);
    shifted_out = shifted_in | oldest;
    own_nbr     = '{value: value_r, age: age_r,
                    le: act_r && (value_r <= ctl.sample), act: act_r};
    // Contents of this slot and the one below once the oldest entry is gone.
    cur = shifted_out ? right_nbr : own_nbr;
    prv = shifted_in ? own_nbr : left_nbr;
    value_nxt = value_r;
    age_nxt   = age_r;
    act_nxt   = act_r;
    if (ctl.clear) begin
      value_nxt = '0;
      age_nxt   = cell_idx;
      act_nxt   = ({1'b0, cell_idx} < ctl.clr_len);
    end else if (ctl.shift && act_r) begin
      if (cur.le) begin
        value_nxt = cur.value;
        age_nxt   = cur.age + IDX_W'(1);
      end else if (prv.le) begin
        value_nxt = ctl.sample;
        age_nxt   = '0;
      end else begin
        value_nxt = prv.value;
        age_nxt   = prv.age + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      age_r   <= cell_idx;
      act_r   <= ({1'b0, cell_idx} < LEN_RESET);
    end else begin
      value_r <= value_nxt;
      age_r   <= age_nxt;
      act_r   <= act_nxt;
    end
  end

endmodule

// ----- rtl/core/sliding_median_u16_core.sv -----
// Running median filter over unsigned 16-bit samples, top level.
// Depends on smed_pkg, smed_cell and sliding_median_u16_core_assert.svh.
//
// Usage:
// Samples arrive on the in_ stream; each transfer yields exactly one median
// on the out_ stream, the element at sorted position length/2 of the newest
// samples, so an even length gives the upper median.
// The window is kept sorted in a chain of 16 cells; each accepted sample
// evicts the oldest cell and inserts itself, so one sample per cycle is
// sustained while out_tready is high; each result shows the cycle after.
// The output register holds a result until it is taken; while the receiver
// stalls, in_tready follows out_tready, so no result is lost.
// The cfg_ port writes the window length (0 acts as 1, above 16 acts as 16)
// and always accepts; every write clears the window to zeros in the same
// cycle. Write it only while the block is idle.
// After reset the length is 5 and the window holds zeros.
module sliding_median_u16_core import smed_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,    // [15:0] sample
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,   // [15:0] median
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data
);

  `include "sliding_median_u16_core_assert.svh"

  logic [LEN_W-1:0]  len_r, len_eff;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              in_xfer, cfg_xfer;
  smed_ctl_t         ctl;
  smed_nbr_t         nbr [MAX_WINDOW];
  logic              chain [MAX_WINDOW+1];
  logic [MAX_WINDOW-1:0] del_vec, act_vec;
  logic [DATA_W-1:0] cell_nxt [MAX_WINDOW];
  logic [IDX_W-1:0]  med_idx;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign med_idx    = IDX_W'(len_r >> 1);

  always_comb begin
    if (cfg_data == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg_data > LEN_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = cfg_data;
    end
    ctl = '{shift: in_xfer, clear: cfg_xfer, sample: in_tdata,
            oldest_age: IDX_W'(len_r - LEN_W'(1)), clr_len: len_eff};
  end

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    smed_nbr_t left_n, right_n;
    if (i == 0) begin : g_first
      assign left_n = '{value: '0, age: '0, le: 1'b1, act: 1'b1};
    end else begin : g_mid_l
      assign left_n = nbr[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_last
      assign right_n = '{value: '0, age: '0, le: 1'b0, act: 1'b0};
    end else begin : g_mid_r
      assign right_n = nbr[i+1];
    end
    smed_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (IDX_W'(i)),
      .ctl         (ctl),
      .left_nbr    (left_n),
      .right_nbr   (right_n),
      .shifted_in  (chain[i]),
      .shifted_out (chain[i+1]),
      .own_nbr     (nbr[i]),
      .oldest      (del_vec[i]),
      .value_nxt   (cell_nxt[i])
    );
    assign act_vec[i] = nbr[i].act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        len_r <= len_eff;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= cell_nxt[med_idx];
    end
  end

  `SMED_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_tvalid)
  `SMED_ASSERT_SAME(a_one_oldest, 1'b1, $onehot(del_vec))
  `SMED_ASSERT_SAME(a_active_matches_len, 1'b1, $countones(act_vec) == int'(len_r))
  `SMED_ASSERT_SAME(a_len_in_range, 1'b1,
                    (len_r != '0) && (len_r <= LEN_W'(MAX_WINDOW)))

endmodule
